// ----- hdl/nsq_pkg.sv -----
// ----------------------------------------------------------------------------
// nsq_pkg: shared types and codes for the named stack/queue manager
// Command and result payloads, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package nsq_pkg;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_PUSH   = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_CREATED  = 3'd0;
    localparam logic [2:0] ST_PUSHED   = 3'd1;
    localparam logic [2:0] ST_POPPED   = 3'd2;
    localparam logic [2:0] ST_EXISTS   = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_POOLFULL = 3'd6;
    localparam logic [2:0] ST_TABFULL  = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] name_key;
        logic        make_queue;
        logic [63:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] popped_value;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_CMP,
        S_NODE_DO,
        S_LINK_TAIL,
        S_RESP
    } state_t;

endpackage

// ----- hdl/named_stack_queue_manager.sv -----
// ----------------------------------------------------------------------------
// named_stack_queue_manager: stacks and queues over a shared linked node pool
// Steps: accept in S_IDLE, then per slot scanned a slot-table read (S_SLOT_RD)
// and key compare (S_SLOT_CMP), stopping at the first key match or after the
// last of CONTAINERS slots; a push or pop adds S_NODE_DO, a push onto a non-empty
// queue also S_LINK_TAIL, then S_RESP; an unused code goes straight to S_RESP.
// One command at a time through a single comparator: a new one is taken only in S_IDLE.
// Reset is instant: valid bits clear, untouched nodes tracked by a fill mark.
// ----------------------------------------------------------------------------
module named_stack_queue_manager #(
    parameter int CONTAINERS = 16,
    parameter int NODES      = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  nsq_pkg::cmd_t cmd,
    output logic          done,
    output nsq_pkg::res_t result
);
    localparam int NW = $clog2(NODES);
    localparam int CW = (CONTAINERS > 1) ? $clog2(CONTAINERS) : 1;

    // one slot-table entry; validity lives in flops beside it
    typedef struct packed {
        logic          is_queue;
        logic [31:0]   key;
        logic [NW-1:0] head;
        logic [NW-1:0] tail;
        logic [NW:0]   count;
    } slot_ent_t;

    nsq_pkg::state_t state_reg, state_next;
    nsq_pkg::cmd_t   cmd_reg, cmd_next;
    nsq_pkg::res_t   res_reg, res_next;

    logic [CW-1:0]         idx_reg, idx_next;
    logic                  free_found_reg, free_found_next;
    logic [CW-1:0]         free_idx_reg, free_idx_next;
    logic [CONTAINERS-1:0] valid_reg, valid_next;
    slot_ent_t             ent_reg, ent_next;

    // free list: head, depth, and fill mark (nodes at or above the mark are
    // untouched since reset and implicitly link to the next node)
    logic [NW-1:0] free_head_reg, free_head_next;
    logic [NW:0]   free_count_reg, free_count_next;
    logic [NW:0]   fresh_reg, fresh_next;
    logic [NW-1:0] new_node_reg, new_node_next;

    // slot table memory
    slot_ent_t slot_mem [CONTAINERS];
    slot_ent_t slot_rdata_reg;
    logic      slot_we;
    slot_ent_t slot_wdata;
    logic [CW-1:0] slot_waddr;

    // node pool port signals
    logic [NW-1:0] pool_rd_addr;
    logic [63:0]   pool_rd_word;
    logic [NW-1:0] pool_rd_link;
    logic          word_we, link_we;
    logic [NW-1:0] word_addr, link_addr, link_data;

    logic [NW-1:0] alloc_link;
    logic          alloc_fresh;

    assign busy   = (state_reg != nsq_pkg::S_IDLE);
    assign done   = (state_reg == nsq_pkg::S_RESP);
    assign result = res_reg;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[idx_reg];
    end

    nsq_node_pool #(
        .NODES(NODES)
    ) u_pool (
        .clk      (clk),
        .rd_addr  (pool_rd_addr),
        .rd_word  (pool_rd_word),
        .rd_link  (pool_rd_link),
        .word_we  (word_we),
        .word_addr(word_addr),
        .word_data(cmd_reg.push_value),
        .link_we  (link_we),
        .link_addr(link_addr),
        .link_data(link_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nsq_pkg::S_IDLE;
            valid_reg      <= '0;
            free_head_reg  <= '0;
            free_count_reg <= (NW+1)'(NODES);
            fresh_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        res_reg        <= res_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        ent_reg        <= ent_next;
        new_node_reg   <= new_node_next;
    end

    // link of the node at the free head: implicit successor if untouched
    assign alloc_fresh = ({1'b0, free_head_reg} >= fresh_reg);
    assign alloc_link  = (free_head_reg == NW'(NODES - 1)) ? '0 :
                         free_head_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        ent_next        = ent_reg;
        new_node_next   = new_node_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        slot_we         = 1'b0;
        slot_waddr      = free_idx_reg;
        slot_wdata      = ent_reg;
        pool_rd_addr    = free_head_reg;
        word_we         = 1'b0;
        word_addr       = free_head_reg;
        link_we         = 1'b0;
        link_addr       = free_head_reg;
        link_data       = free_head_reg;

        unique case (state_reg)
            nsq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    res_next        = '{status: nsq_pkg::ST_MISSING, popped_value: '0};
                    unique case (cmd.kind)
                        nsq_pkg::KIND_CREATE, nsq_pkg::KIND_PUSH, nsq_pkg::KIND_POP:
                            state_next = nsq_pkg::S_SLOT_RD;
                        default:
                            state_next = nsq_pkg::S_RESP;
                    endcase
                end
            end

            nsq_pkg::S_SLOT_RD:
            begin
                // note the lowest free slot on the way past
                if (!valid_reg[idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                state_next = nsq_pkg::S_SLOT_CMP;
            end

            nsq_pkg::S_SLOT_CMP:
            begin
                pool_rd_addr = (cmd_reg.kind == nsq_pkg::KIND_POP) ?
                               slot_rdata_reg.head : free_head_reg;
                if (valid_reg[idx_reg] && slot_rdata_reg.key == cmd_reg.name_key)
                begin
                    ent_next      = slot_rdata_reg;
                    free_idx_next = idx_reg;  // matched slot from here on
                    state_next    = nsq_pkg::S_RESP;
                    unique case (cmd_reg.kind)
                        nsq_pkg::KIND_CREATE:
                            res_next.status = nsq_pkg::ST_EXISTS;
                        nsq_pkg::KIND_PUSH:
                        begin
                            if (free_count_reg == '0)
                                res_next.status = nsq_pkg::ST_POOLFULL;
                            else
                                state_next = nsq_pkg::S_NODE_DO;
                        end
                        default:
                        begin
                            if (slot_rdata_reg.count == '0)
                                res_next.status = nsq_pkg::ST_EMPTY;
                            else
                                state_next = nsq_pkg::S_NODE_DO;
                        end
                    endcase
                end
                else if (idx_reg != CW'(CONTAINERS - 1))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = nsq_pkg::S_SLOT_RD;
                end
                else
                begin
                    state_next = nsq_pkg::S_RESP;
                    if (cmd_reg.kind == nsq_pkg::KIND_CREATE)
                    begin
                        if (free_found_reg)
                        begin
                            slot_we    = 1'b1;
                            slot_wdata = '{is_queue: cmd_reg.make_queue,
                                           key: cmd_reg.name_key,
                                           head: '0, tail: '0, count: '0};
                            valid_next[free_idx_reg] = 1'b1;
                            res_next.status = nsq_pkg::ST_CREATED;
                        end
                        else
                        begin
                            res_next.status = nsq_pkg::ST_TABFULL;
                        end
                    end
                end
            end

            nsq_pkg::S_NODE_DO:
            begin
                slot_we    = 1'b1;
                slot_wdata = ent_reg;
                state_next = nsq_pkg::S_RESP;
                if (cmd_reg.kind == nsq_pkg::KIND_PUSH)
                begin
                    // take node from free list head
                    free_head_next  = alloc_fresh ? alloc_link : pool_rd_link;
                    free_count_next = free_count_reg - 1'b1;
                    if (alloc_fresh)
                        fresh_next = {1'b0, free_head_reg} + 1'b1;
                    word_we   = 1'b1;
                    link_we   = 1'b1;
                    link_addr = free_head_reg;
                    new_node_next = free_head_reg;
                    slot_wdata.count = ent_reg.count + 1'b1;
                    if (ent_reg.count == '0)
                    begin
                        link_data       = free_head_reg;
                        slot_wdata.head = free_head_reg;
                        slot_wdata.tail = free_head_reg;
                    end
                    else if (ent_reg.is_queue)
                    begin
                        link_data       = free_head_reg;
                        slot_wdata.tail = free_head_reg;
                        state_next      = nsq_pkg::S_LINK_TAIL;
                    end
                    else
                    begin
                        link_data       = ent_reg.head;
                        slot_wdata.head = free_head_reg;
                    end
                    res_next.status = nsq_pkg::ST_PUSHED;
                end
                else
                begin
                    // unlink head, return it to the free list
                    res_next.status       = nsq_pkg::ST_POPPED;
                    res_next.popped_value = pool_rd_word;
                    slot_wdata.head       = pool_rd_link;
                    slot_wdata.count      = ent_reg.count - 1'b1;
                    link_we               = 1'b1;
                    link_addr             = ent_reg.head;
                    link_data             = free_head_reg;
                    free_head_next        = ent_reg.head;
                    free_count_next       = free_count_reg + 1'b1;
                end
            end

            nsq_pkg::S_LINK_TAIL:
            begin
                // old queue tail points at the new node
                link_we    = 1'b1;
                link_addr  = ent_reg.tail;
                link_data  = new_node_reg;
                state_next = nsq_pkg::S_RESP;
            end

            nsq_pkg::S_RESP:
            begin
                state_next = nsq_pkg::S_IDLE;
            end

            default:
            begin
                state_next = nsq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/nsq_node_pool.sv -----
// ----------------------------------------------------------------------------
// nsq_node_pool: node storage
// Word and link arrays, one shared read address, registered read data,
// independent write ports for word and link.
// ----------------------------------------------------------------------------
module nsq_node_pool #(
    parameter int NODES = 256
) (
    input  logic                     clk,
    input  logic [$clog2(NODES)-1:0] rd_addr,
    output logic [63:0]              rd_word,
    output logic [$clog2(NODES)-1:0] rd_link,
    input  logic                     word_we,
    input  logic [$clog2(NODES)-1:0] word_addr,
    input  logic [63:0]              word_data,
    input  logic                     link_we,
    input  logic [$clog2(NODES)-1:0] link_addr,
    input  logic [$clog2(NODES)-1:0] link_data
);
    localparam int NW = $clog2(NODES);

    logic [63:0]   word_mem [NODES];
    logic [NW-1:0] link_mem [NODES];

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= word_data;
        end
        rd_word <= word_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
        rd_link <= link_mem[rd_addr];
    end

endmodule

// ----- hdl/nsq_checker.sv -----
// ----------------------------------------------------------------------------
// nsq_checker: port-level checks for the stack/queue manager
// Strobe timing against busy, and popped value zero on non-pop results.
// ----------------------------------------------------------------------------
module nsq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input nsq_pkg::res_t result
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobe while not busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done not a single strobe ending the command");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != nsq_pkg::ST_POPPED) |-> (result.popped_value == '0))
        else $error("popped value non-zero on non-pop result");

endmodule

bind named_stack_queue_manager nsq_checker u_nsq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

// ----- verif/tb_named_stack_queue_manager.sv -----
// ----------------------------------------------------------------------------
// tb_named_stack_queue_manager: self-checking bench for the stack/queue manager
// Drives create/push/pop commands, predicts every result with a local model
// of the slot table and node pool, and checks each done strobe in order.
// ----------------------------------------------------------------------------
module tb_named_stack_queue_manager;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CONTAINERS = 16;
    localparam int NODES      = 256;
    localparam longint CYCLE_LIMIT = 2000000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    nsq_pkg::cmd_t cmd = '0;
    logic          done;
    nsq_pkg::res_t result;

    named_stack_queue_manager #(.CONTAINERS(CONTAINERS), .NODES(NODES)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .done(done), .result(result)
    );

    always #6 clk = ~clk;

    // ---- predictor state: own copy of slot table and node pool ----
    logic        tbl_valid [CONTAINERS];
    logic        tbl_queue [CONTAINERS];
    logic [31:0] tbl_key   [CONTAINERS];
    logic [7:0]  tbl_head  [CONTAINERS];
    logic [7:0]  tbl_tail  [CONTAINERS];
    int          tbl_count [CONTAINERS];
    logic [63:0] pool_word [NODES];
    logic [7:0]  pool_link [NODES];
    logic [7:0]  pool_free_head;
    int          pool_free_count;

    nsq_pkg::res_t pending_results[$];
    int            fail_count = 0;
    longint        cycle_count = 0;
    bit            calm = 1'b0;   // stretch with no sender gaps

    function automatic int lookup_slot(logic [31:0] key);
        for (int s = 0; s < CONTAINERS; s++)
            if (tbl_valid[s] && tbl_key[s] == key)
                return s;
        return -1;
    endfunction

    // work out the answer to one command and update the local state
    function automatic nsq_pkg::res_t apply_command(nsq_pkg::cmd_t c);
        nsq_pkg::res_t r;
        int s;
        logic [7:0] n;
        r = '0;
        s = lookup_slot(c.name_key);
        case (c.kind)
            nsq_pkg::KIND_CREATE: begin
                if (s >= 0)
                    r.status = nsq_pkg::ST_EXISTS;
                else
                begin
                    r.status = nsq_pkg::ST_TABFULL;
                    for (int i = 0; i < CONTAINERS; i++)
                        if (!tbl_valid[i] && r.status == nsq_pkg::ST_TABFULL)
                        begin
                            tbl_valid[i] = 1'b1;
                            tbl_queue[i] = c.make_queue;
                            tbl_key[i]   = c.name_key;
                            tbl_head[i]  = '0;
                            tbl_tail[i]  = '0;
                            tbl_count[i] = 0;
                            r.status = nsq_pkg::ST_CREATED;
                        end
                end
            end
            nsq_pkg::KIND_PUSH: begin
                if (s < 0)
                    r.status = nsq_pkg::ST_MISSING;
                else if (pool_free_count == 0)
                    r.status = nsq_pkg::ST_POOLFULL;
                else
                begin
                    n = pool_free_head;
                    pool_free_head = pool_link[n];
                    pool_free_count--;
                    pool_word[n] = c.push_value;
                    if (tbl_count[s] == 0)
                    begin
                        pool_link[n] = n;
                        tbl_head[s] = n;
                        tbl_tail[s] = n;
                    end
                    else if (tbl_queue[s])
                    begin
                        pool_link[n] = n;
                        pool_link[tbl_tail[s]] = n;
                        tbl_tail[s] = n;
                    end
                    else
                    begin
                        pool_link[n] = tbl_head[s];
                        tbl_head[s] = n;
                    end
                    tbl_count[s]++;
                    r.status = nsq_pkg::ST_PUSHED;
                end
            end
            nsq_pkg::KIND_POP: begin
                if (s < 0)
                    r.status = nsq_pkg::ST_MISSING;
                else if (tbl_count[s] == 0)
                    r.status = nsq_pkg::ST_EMPTY;
                else
                begin
                    n = tbl_head[s];
                    r.popped_value = pool_word[n];
                    tbl_head[s] = pool_link[n];
                    tbl_count[s]--;
                    pool_link[n] = pool_free_head;
                    pool_free_head = n;
                    pool_free_count++;
                    r.status = nsq_pkg::ST_POPPED;
                end
            end
            default: r.status = nsq_pkg::ST_MISSING;   // unused command code
        endcase
        return r;
    endfunction

    // one transfer: drive at falling edge, held until accepted
    task automatic send_command(logic [1:0] k, logic [31:0] key, logic q, logic [63:0] v);
        nsq_pkg::cmd_t c;
        c.kind = k; c.name_key = key; c.make_queue = q; c.push_value = v;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 22)
            @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_command(c));
        @(negedge clk);
        start <= 1'b0;
        cmd   <= nsq_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom});
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker: every strobe must match the oldest expectation
    always @(posedge clk)
    begin
        nsq_pkg::res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result status=%0d", result.status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.popped_value !== want.popped_value)
                begin
                    $error("popped_value: expected %h actual %h",
                           want.popped_value, result.popped_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // small key set so commands mostly hit live containers
    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom;
            default: return 32'h100 + $urandom_range(19);
        endcase
    endfunction

    // extremes of every field and each special case
    task automatic test_directed();
        send_command(nsq_pkg::KIND_POP, 32'h0, 1'b0, 64'h0);             // missing
        send_command(nsq_pkg::KIND_PUSH, 32'hFFFF_FFFF, 1'b1, '1);       // missing
        send_command(nsq_pkg::KIND_UNUSED, 32'h0, 1'b1, '1);             // unused code
        send_command(nsq_pkg::KIND_CREATE, 32'h0, 1'b0, '1);             // stack
        send_command(nsq_pkg::KIND_CREATE, 32'h0, 1'b1, '0);             // exists
        send_command(nsq_pkg::KIND_CREATE, 32'hFFFF_FFFF, 1'b1, '0);     // queue
        send_command(nsq_pkg::KIND_POP, 32'h0, 1'b0, '0);                // empty
        send_command(nsq_pkg::KIND_PUSH, 32'h0, 1'b0, 64'h0);
        send_command(nsq_pkg::KIND_PUSH, 32'h0, 1'b0, '1);
        send_command(nsq_pkg::KIND_PUSH, 32'hFFFF_FFFF, 1'b0, 64'h0123_4567_89AB_CDEF);
        send_command(nsq_pkg::KIND_PUSH, 32'hFFFF_FFFF, 1'b0, 64'hFEDC_BA98_7654_3210);
        send_command(nsq_pkg::KIND_POP, 32'h0, 1'b0, '0);
        send_command(nsq_pkg::KIND_POP, 32'hFFFF_FFFF, 1'b0, '0);
        send_command(nsq_pkg::KIND_POP, 32'h0, 1'b0, '0);
        send_command(nsq_pkg::KIND_POP, 32'hFFFF_FFFF, 1'b0, '0);
        send_command(nsq_pkg::KIND_POP, 32'hFFFF_FFFF, 1'b0, '0);        // empty
        for (int i = 0; i < 15; i++)                                     // fill table
            send_command(nsq_pkg::KIND_CREATE, 32'h100 + i, i[0], '0);
        wait_drained();
    endtask

    // fill the pool to overflow, then pop from it
    task automatic test_pool_full();
        for (int i = 0; i < NODES + 3; i++)
            send_command(nsq_pkg::KIND_PUSH, 32'h100 + $urandom_range(13), 1'b0,
                         {$urandom, $urandom});
        send_command(nsq_pkg::KIND_CREATE, 32'h7777, 1'b0, '0);          // table full
        for (int i = 0; i < NODES + 20; i++)
            send_command(nsq_pkg::KIND_POP, 32'h100 + $urandom_range(13), 1'b0, '0);
        wait_drained();                                                  // sender holds off
    endtask

    // random mix of create, push, pop and unused codes
    task automatic test_random();
        logic [1:0] k;
        for (int i = 0; i < 880; i++)
        begin
            calm = (i >= 400 && i < 550);
            case ($urandom_range(9))
                0:       k = nsq_pkg::KIND_CREATE;
                1:       k = nsq_pkg::KIND_UNUSED;
                2, 3, 4: k = nsq_pkg::KIND_POP;
                default: k = nsq_pkg::KIND_PUSH;
            endcase
            send_command(k, pick_key(), 1'($urandom_range(1)), {$urandom, $urandom});
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int s = 0; s < CONTAINERS; s++)
        begin
            tbl_valid[s] = 1'b0; tbl_queue[s] = 1'b0; tbl_key[s] = '0;
            tbl_head[s] = '0; tbl_tail[s] = '0; tbl_count[s] = 0;
        end
        for (int i = 0; i < NODES; i++)
        begin
            pool_word[i] = '0;
            pool_link[i] = 8'(i + 1);
        end
        pool_free_head = '0;
        pool_free_count = NODES;
        test_directed();
        test_pool_full();
        test_random();
        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/nsq_pkg.sv
hdl/nsq_node_pool.sv
hdl/named_stack_queue_manager.sv
hdl/nsq_checker.sv
verif/tb_named_stack_queue_manager.sv
